// File: src/scfp_pkg.sv
package scfp_pkg;

    // Frame layout
    localparam int PAYLOAD_LEN   = 4;
    localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);
    localparam int COUNT_W       = 3;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] FOOTER     = 8'h5D;

    localparam logic [7:0] CIRCLE_X_RESET = 8'd80;
    localparam logic [7:0] CIRCLE_Y_RESET = 8'd60;

    // Configuration register indexes
    localparam int         CFG_IDX_W          = 3;
    localparam int         NUM_CODES          = 6;
    localparam logic [2:0] CFG_CODE_HEIGHT    = 3'd0;
    localparam logic [2:0] CFG_CODE_POSITION  = 3'd1;
    localparam logic [2:0] CFG_CODE_SEARCH    = 3'd2;
    localparam logic [2:0] CFG_CODE_LANDING   = 3'd3;
    localparam logic [2:0] CFG_CODE_DIST_LOW  = 3'd4;
    localparam logic [2:0] CFG_CODE_DIST_HIGH = 3'd5;

    // Update kinds
    localparam logic [2:0] KIND_HEIGHT    = 3'd0;
    localparam logic [2:0] KIND_POSITION  = 3'd1;
    localparam logic [2:0] KIND_SEARCH    = 3'd2;
    localparam logic [2:0] KIND_LANDING   = 3'd3;
    localparam logic [2:0] KIND_DIST_LOW  = 3'd4;
    localparam logic [2:0] KIND_DIST_HIGH = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd6;

    typedef logic [PAYLOAD_LEN-1:0][7:0] t_payload;

    // Frame event from the parser to the value store
    typedef struct packed {
        logic       good;
        logic [7:0] command;
        t_payload   payload;
    } t_frame_evt;

    // Snapshot of all stored values
    typedef struct packed {
        logic [15:0] height;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  search_char;
        logic [7:0]  search_count;
        logic [7:0]  circle_x;
        logic [7:0]  circle_y;
        logic [15:0] dist0;
        logic [15:0] dist1;
        logic [15:0] dist2;
        logic [15:0] dist3;
    } t_snapshot;

endpackage

// File: src/scfp_frame_fsm.sv
module scfp_frame_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output scfp_pkg::t_frame_evt o_evt
);
    import scfp_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_CMD     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_FOOTER  = 3'd4;

    logic [2:0]         r_phase,   n_phase;
    logic [7:0]         r_command, n_command;
    logic [COUNT_W-1:0] r_count,   n_count;
    t_payload           r_payload, n_payload;

    // Next parse state for the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_count   = r_count;
        n_payload = r_payload;
        case (r_phase)
            PH_SECOND: begin
                n_phase = (i_byte == HDR_SECOND) ? PH_CMD : PH_HUNT;
            end
            PH_CMD: begin
                n_command = i_byte;
                n_count   = '0;
                n_phase   = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_payload[r_count[PAYLOAD_IDX_W-1:0]] = i_byte;
                n_count = r_count + COUNT_W'(1);
                if (n_count >= COUNT_W'(PAYLOAD_LEN)) begin
                    n_phase = PH_FOOTER;
                end
            end
            PH_FOOTER: begin
                n_phase = PH_HUNT;
                n_count = '0;
            end
            default: begin
                n_phase = (i_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
            end
        endcase
    end

    // Advance control state on each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_command <= '0;
            r_count   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_count   <= n_count;
        end
    end

    // Hold payload bytes; every frame writes all of them before use
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_payload <= n_payload;
        end
    end

    // A good footer completes the frame
    always_comb begin
        o_evt.good    = (r_phase == PH_FOOTER) && (i_byte == FOOTER);
        o_evt.command = r_command;
        o_evt.payload = r_payload;
    end

    a_footer_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FOOTER) |-> (r_count == COUNT_W'(PAYLOAD_LEN)))
        else $error("footer phase without a full payload");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_count < COUNT_W'(PAYLOAD_LEN)))
        else $error("payload count overran");

    a_cmd_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CMD) |=> (r_phase == PH_PAYLOAD && r_count == '0))
        else $error("command byte did not open the payload");

endmodule

// File: src/scfp_value_store.sv
module scfp_value_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [7:0]                            i_cfg_data,
    input  logic                                  i_step,
    input  scfp_pkg::t_frame_evt                  i_evt,
    output logic [2:0]                            o_kind,
    output scfp_pkg::t_snapshot                   o_snap
);
    import scfp_pkg::*;

    logic [NUM_CODES-1:0][7:0] r_codes;
    t_snapshot                 r_snap, n_snap;
    logic [2:0]                kind;
    logic [15:0]               pair_lo, pair_hi;

    // Write command codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes[CFG_CODE_HEIGHT]    <= 8'd1;
            r_codes[CFG_CODE_POSITION]  <= 8'd2;
            r_codes[CFG_CODE_SEARCH]    <= 8'd3;
            r_codes[CFG_CODE_LANDING]   <= 8'd4;
            r_codes[CFG_CODE_DIST_LOW]  <= 8'd5;
            r_codes[CFG_CODE_DIST_HIGH] <= 8'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CODE_HEIGHT:    r_codes[CFG_CODE_HEIGHT]    <= i_cfg_data;
                CFG_CODE_POSITION:  r_codes[CFG_CODE_POSITION]  <= i_cfg_data;
                CFG_CODE_SEARCH:    r_codes[CFG_CODE_SEARCH]    <= i_cfg_data;
                CFG_CODE_LANDING:   r_codes[CFG_CODE_LANDING]   <= i_cfg_data;
                CFG_CODE_DIST_LOW:  r_codes[CFG_CODE_DIST_LOW]  <= i_cfg_data;
                CFG_CODE_DIST_HIGH: r_codes[CFG_CODE_DIST_HIGH] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Match the command, lowest register wins
    always_comb begin
        kind = KIND_UNKNOWN;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (r_codes[k] == i_evt.command) begin
                kind = 3'(k);
            end
        end
    end

    assign pair_lo = {i_evt.payload[0], i_evt.payload[1]};
    assign pair_hi = {i_evt.payload[2], i_evt.payload[3]};

    // Apply the payload to the selected values
    always_comb begin
        n_snap = r_snap;
        case (kind)
            KIND_HEIGHT: begin
                n_snap.height = pair_lo;
            end
            KIND_POSITION: begin
                n_snap.pos_x = pair_lo;
                n_snap.pos_y = pair_hi;
            end
            KIND_SEARCH: begin
                n_snap.search_char  = i_evt.payload[0];
                n_snap.search_count = i_evt.payload[1];
            end
            KIND_LANDING: begin
                n_snap.circle_x = i_evt.payload[0];
                n_snap.circle_y = i_evt.payload[1];
            end
            KIND_DIST_LOW: begin
                n_snap.dist0 = pair_lo;
                n_snap.dist1 = pair_hi;
            end
            KIND_DIST_HIGH: begin
                n_snap.dist2 = pair_lo;
                n_snap.dist3 = pair_hi;
            end
            default: ;
        endcase
    end

    // Commit the update on a good frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= '{height:       16'h0000,
                        pos_x:        16'h0000,
                        pos_y:        16'h0000,
                        search_char:  8'h00,
                        search_count: 8'h00,
                        circle_x:     CIRCLE_X_RESET,
                        circle_y:     CIRCLE_Y_RESET,
                        dist0:        16'h0000,
                        dist1:        16'h0000,
                        dist2:        16'h0000,
                        dist3:        16'h0000};
        end else if (i_step) begin
            r_snap <= n_snap;
        end
    end

    assign o_kind = kind;
    assign o_snap = n_snap;

    a_hold_without_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_snap))
        else $error("stored values changed without a frame");

    a_unknown_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && kind == KIND_UNKNOWN) |=> $stable(r_snap))
        else $error("unknown command changed stored values");

    a_first_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_codes[CFG_CODE_HEIGHT] == i_evt.command) |-> (kind == KIND_HEIGHT))
        else $error("height code did not take priority");

endmodule

// File: src/serial_command_frame_parser_unit.sv
// Channel   | Handshake                 | Payload
// rx byte   | i_rx_valid / o_rx_ready   | i_rx_byte
// result    | o_res_valid / i_res_ready | o_update_kind, stored value snapshot
// config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One byte per cycle is accepted while the input side is not stalled; each byte
// passes an input register, then the parse and store update logic, and a good
// frame's result then enters the result register as its footer beat advances.
// Reset is synchronous, active low; it restores the default command codes.
// The input side stalls only when a finished frame meets a result still held.
module serial_command_frame_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [2:0]                      o_update_kind,
    output logic [15:0]                     o_height_value,
    output logic [15:0]                     o_position_x,
    output logic [15:0]                     o_position_y,
    output logic [7:0]                      o_search_char,
    output logic [7:0]                      o_search_count,
    output logic [7:0]                      o_circle_x,
    output logic [7:0]                      o_circle_y,
    output logic [15:0]                     o_distance_zero,
    output logic [15:0]                     o_distance_one,
    output logic [15:0]                     o_distance_two,
    output logic [15:0]                     o_distance_three
);
    import scfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [2:0] r_out_kind;
    t_snapshot  r_out_snap;

    t_frame_evt evt;
    logic [2:0] kind;
    t_snapshot  snap;
    logic       fire;
    logic       load;
    logic       accept;

    // Advance the held byte unless its result would overwrite a waiting one
    assign fire   = r_in_valid && (!evt.good || !r_out_valid || i_res_ready);
    assign load   = fire && evt.good;
    assign accept = i_rx_valid && o_rx_ready;
    assign o_rx_ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scfp_frame_fsm u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    scfp_value_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (load),
        .i_evt       (evt),
        .o_kind      (kind),
        .o_snap      (snap)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= kind;
            r_out_snap <= snap;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_update_kind    = r_out_kind;
    assign o_height_value   = r_out_snap.height;
    assign o_position_x     = r_out_snap.pos_x;
    assign o_position_y     = r_out_snap.pos_y;
    assign o_search_char    = r_out_snap.search_char;
    assign o_search_count   = r_out_snap.search_count;
    assign o_circle_x       = r_out_snap.circle_x;
    assign o_circle_y       = r_out_snap.circle_y;
    assign o_distance_zero  = r_out_snap.dist0;
    assign o_distance_one   = r_out_snap.dist1;
    assign o_distance_two   = r_out_snap.dist2;
    assign o_distance_three = r_out_snap.dist3;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_out_valid) |-> i_res_ready)
        else $error("result overwritten before it was taken");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_update_kind <= KIND_UNKNOWN))
        else $error("update kind out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_rx_ready)
        else $error("input stalled with an empty input register");

endmodule
